@@ rtl/core/mpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfr_pkg
// Shared types, constants and the bytewise CRC-16/Modbus update for the page
// frame receiver.
// ----------------------------------------------------------------------------
package mpfr_pkg;

  localparam logic [7:0]  FUNC_CODE    = 8'h10;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  ADDR_DEFAULT = 8'd101;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_MORE    = 2'd1;
  localparam logic [1:0] KIND_LAST    = 2'd2;
  localparam logic [1:0] KIND_CRC_ERR = 2'd3;

  typedef struct packed {
    logic [15:0] page_number;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic [1:0]  result_kind;
  } result_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/mpfr_parser.sv @@
// ----------------------------------------------------------------------------
// mpfr_parser
// Frame parser: phase register, running CRC, page field and payload counter.
// Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module mpfr_parser #(
  parameter int PAYLOAD_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               byte_en,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output mpfr_pkg::result_t  res
);

  localparam int CNT_W = (PAYLOAD_BYTES > 2) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_FUNC    = 4'd1;
  localparam logic [3:0] PH_PAGE_HI = 4'd2;
  localparam logic [3:0] PH_PAGE_LO = 4'd3;
  localparam logic [3:0] PH_NREG_HI = 4'd4;
  localparam logic [3:0] PH_NREG_LO = 4'd5;
  localparam logic [3:0] PH_NBYTES  = 4'd6;
  localparam logic [3:0] PH_DATA    = 4'd7;
  localparam logic [3:0] PH_CRC_LO  = 4'd8;
  localparam logic [3:0] PH_CRC_HI  = 4'd9;

  logic [7:0]       addr_r;
  logic [3:0]       phase_r, phase_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      page_r, page_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             more_r, more_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [15:0]      crc_src;
  logic [15:0]      crc_upd;
  logic             good;

  assign crc_src = (phase_r == PH_FUNC || phase_r == PH_PAGE_HI || phase_r == PH_PAGE_LO ||
                    phase_r == PH_NREG_HI || phase_r == PH_NREG_LO ||
                    phase_r == PH_NBYTES || phase_r == PH_DATA) ? crc_r : mpfr_pkg::CRC_INIT;
  assign crc_upd = mpfr_pkg::crc_add(crc_src, rx_byte);
  assign good    = (crc_lo_r == crc_r[7:0]) && (rx_byte == crc_r[15:8]);

  always_comb begin
    phase_nxt       = phase_r;
    crc_nxt         = crc_r;
    page_nxt        = page_r;
    cnt_nxt         = cnt_r;
    more_nxt        = more_r;
    crc_lo_nxt      = crc_lo_r;
    res_valid       = 1'b0;
    res.result_kind = mpfr_pkg::KIND_DATA;
    res.data_byte   = 8'h00;
    res.byte_offset = 8'h00;
    res.page_number = page_r;
    unique case (phase_r)
      PH_FUNC: begin
        crc_nxt   = crc_upd;
        phase_nxt = (rx_byte == mpfr_pkg::FUNC_CODE) ? PH_PAGE_HI : PH_IDLE;
      end
      PH_PAGE_HI: begin
        crc_nxt   = crc_upd;
        page_nxt  = {rx_byte, page_r[7:0]};
        phase_nxt = PH_PAGE_LO;
      end
      PH_PAGE_LO: begin
        crc_nxt   = crc_upd;
        page_nxt  = {page_r[15:8], rx_byte};
        phase_nxt = PH_NREG_HI;
      end
      PH_NREG_HI: begin
        crc_nxt   = crc_upd;
        phase_nxt = PH_NREG_LO;
      end
      PH_NREG_LO: begin
        crc_nxt   = crc_upd;
        phase_nxt = PH_NBYTES;
      end
      PH_NBYTES: begin
        crc_nxt   = crc_upd;
        more_nxt  = (rx_byte == 8'h00);
        cnt_nxt   = '0;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        crc_nxt         = crc_upd;
        res_valid       = 1'b1;
        res.data_byte   = rx_byte;
        res.byte_offset = 8'(cnt_r);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          phase_nxt = PH_CRC_LO;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_valid       = 1'b1;
        res.result_kind = good ? (more_r ? mpfr_pkg::KIND_MORE : mpfr_pkg::KIND_LAST)
                               : mpfr_pkg::KIND_CRC_ERR;
        phase_nxt       = PH_IDLE;
        crc_nxt         = mpfr_pkg::CRC_INIT;
        cnt_nxt         = '0;
      end
      default: begin
        if (rx_byte == addr_r) begin
          crc_nxt   = crc_upd;
          cnt_nxt   = '0;
          phase_nxt = PH_FUNC;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= mpfr_pkg::ADDR_DEFAULT;
      phase_r  <= PH_IDLE;
      crc_r    <= mpfr_pkg::CRC_INIT;
      page_r   <= '0;
      cnt_r    <= '0;
      more_r   <= 1'b0;
      crc_lo_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
      if (byte_en) begin
        phase_r  <= phase_nxt;
        crc_r    <= crc_nxt;
        page_r   <= page_nxt;
        cnt_r    <= cnt_nxt;
        more_r   <= more_nxt;
        crc_lo_r <= crc_lo_nxt;
      end
    end
  end

endmodule

@@ rtl/core/mpfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// mpfr_out_reg
// Result register on the master side; takes a new result whenever the held
// one is gone or leaves in the same cycle.
// ----------------------------------------------------------------------------
module mpfr_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               res_valid,
  input  mpfr_pkg::result_t  res,
  output logic               can_load,
  output logic               out_tvalid,
  input  logic               out_tready,
  output mpfr_pkg::result_t  out_res
);

  logic              valid_r;
  mpfr_pkg::result_t res_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

@@ rtl/core/modbus_page_frame_receiver.sv @@
// Output: a result is registered and shows on out_tvalid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; in_tready drops only while a held result
// is not taken (the single output register sets this).
// Reset: synchronous, active low; idle phase, CRC 0xFFFF, address 101,
// no result pending.
// ----------------------------------------------------------------------------
// modbus_page_frame_receiver
// Receives a fixed page-write frame byte by byte, passes out payload bytes
// with their offsets and reports the frame outcome after the CRC.
// ----------------------------------------------------------------------------
module modbus_page_frame_receiver #(
  parameter int PAYLOAD_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // device_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] data_byte, [15:8] byte_offset, [31:16] page_number
  output logic [1:0]  out_tuser      // [1:0] result_kind
);

  logic              accept;
  logic              can_load;
  logic              res_valid;
  mpfr_pkg::result_t res;
  mpfr_pkg::result_t out_res;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  mpfr_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_en     (accept),
    .rx_byte     (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  mpfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res_valid  (res_valid),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.page_number, out_res.byte_offset, out_res.data_byte};
  assign out_tuser = out_res.result_kind;

endmodule

@@ tb/sv/modbus_page_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_page_frame_receiver_tb
// Feeds byte streams of page-write frames, well-formed and broken, to the
// receiver. A bytewise predictor tracks the frame parse and CRC and queues
// the expected payload bytes and frame outcomes; the monitor checks every
// result against it. Random bursts on input, random backpressure on output.
// ----------------------------------------------------------------------------
module modbus_page_frame_receiver_tb;

  localparam int PAYLOAD = 256;

  localparam logic [3:0] RX_IDLE    = 4'd0;
  localparam logic [3:0] RX_FUNC    = 4'd1;
  localparam logic [3:0] RX_PAGE_HI = 4'd2;
  localparam logic [3:0] RX_PAGE_LO = 4'd3;
  localparam logic [3:0] RX_NREG_HI = 4'd4;
  localparam logic [3:0] RX_NREG_LO = 4'd5;
  localparam logic [3:0] RX_NBYTES  = 4'd6;
  localparam logic [3:0] RX_DATA    = 4'd7;
  localparam logic [3:0] RX_CRC_LO  = 4'd8;
  localparam logic [3:0] RX_CRC_HI  = 4'd9;

  typedef enum int {FAULT_NONE, FAULT_CRC_LO, FAULT_CRC_HI, FAULT_DATA} frame_fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] data_byte, [15:8] byte_offset, [31:16] page_number
  logic [1:0]  out_tuser;          // [1:0] result_kind

  modbus_page_frame_receiver #(.PAYLOAD_BYTES(PAYLOAD)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #2 clk = ~clk;

  // frame parser mirror
  logic [7:0]  dev_addr = mpfr_pkg::ADDR_DEFAULT;
  logic [3:0]  rx_phase = RX_IDLE;
  logic [15:0] crc_acc = mpfr_pkg::CRC_INIT;
  logic [15:0] page_acc = '0;
  int          offset_count = 0;
  logic        more_pages = 1'b0;
  logic [7:0]  crc_lo_held = '0;

  mpfr_pkg::result_t expected_results[$];
  logic [7:0]        pending_bytes[$];
  logic [7:0]        frame_bytes[$];

  int bytes_queued = 0;
  int bytes_accepted = 0;
  int results_checked = 0;
  int frames_built = 0;
  int mismatch_count = 0;
  int outcome_count[4] = '{0, 0, 0, 0};
  int addr_settings = 0;

  // driver pacing
  int burst_left = 0;
  int gap_left = 0;
  // receiver pacing
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age = 0;
  int          hold_left = 0;
  logic        long_stall_req = 1'b0;
  logic        long_stall_seen = 1'b0;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[15:1]} ^ ((r[0] ^ b[k]) ? mpfr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    mpfr_pkg::result_t r;
    logic [15:0]       crc_upd;
    crc_upd = crc16_step(crc_acc, b);
    r = '0;
    r.page_number = page_acc;
    unique case (rx_phase)
      RX_FUNC: begin
        crc_acc = crc_upd;
        rx_phase = (b == mpfr_pkg::FUNC_CODE) ? RX_PAGE_HI : RX_IDLE;
      end
      RX_PAGE_HI: begin
        crc_acc = crc_upd;
        page_acc[15:8] = b;
        rx_phase = RX_PAGE_LO;
      end
      RX_PAGE_LO: begin
        crc_acc = crc_upd;
        page_acc[7:0] = b;
        rx_phase = RX_NREG_HI;
      end
      RX_NREG_HI: begin
        crc_acc = crc_upd;
        rx_phase = RX_NREG_LO;
      end
      RX_NREG_LO: begin
        crc_acc = crc_upd;
        rx_phase = RX_NBYTES;
      end
      RX_NBYTES: begin
        crc_acc = crc_upd;
        more_pages = (b == 8'h00);
        offset_count = 0;
        rx_phase = RX_DATA;
      end
      RX_DATA: begin
        crc_acc = crc_upd;
        r.result_kind = mpfr_pkg::KIND_DATA;
        r.data_byte = b;
        r.byte_offset = 8'(offset_count);
        expected_results.push_back(r);
        if (offset_count + 1 >= PAYLOAD) begin
          offset_count = 0;
          rx_phase = RX_CRC_LO;
        end else begin
          offset_count++;
        end
      end
      RX_CRC_LO: begin
        crc_lo_held = b;
        rx_phase = RX_CRC_HI;
      end
      RX_CRC_HI: begin
        if ({b, crc_lo_held} == crc_acc) begin
          r.result_kind = more_pages ? mpfr_pkg::KIND_MORE : mpfr_pkg::KIND_LAST;
        end else begin
          r.result_kind = mpfr_pkg::KIND_CRC_ERR;
        end
        expected_results.push_back(r);
        rx_phase = RX_IDLE;
        crc_acc = mpfr_pkg::CRC_INIT;
        offset_count = 0;
      end
      default: begin
        if (b == dev_addr) begin
          crc_acc = crc16_step(mpfr_pkg::CRC_INIT, b);
          offset_count = 0;
          rx_phase = RX_FUNC;
        end else begin
          rx_phase = RX_IDLE;
        end
      end
    endcase
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata);
        bytes_accepted++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (long_stall_req != long_stall_seen) begin
        long_stall_seen = long_stall_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom);
            2: ready_pattern = 16'($urandom) | 16'($urandom);
            default: ready_pattern = 16'($urandom) & 16'($urandom);
          endcase
          if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
          pattern_age = $urandom_range(32, 128);
        end
        pattern_age--;
        out_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // monitor
  always @(posedge clk) begin
    mpfr_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      outcome_count[out_tuser]++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0d data %02h offset %0d page %04h",
                               out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[31:16]));
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.result_kind || out_tdata[7:0] !== want.data_byte ||
            out_tdata[15:8] !== want.byte_offset || out_tdata[31:16] !== want.page_number) begin
          note_failure($sformatf({"result %0d: expected kind %0d data %02h offset %0d page %04h,",
                                  " got kind %0d data %02h offset %0d page %04h"},
                                 results_checked, want.result_kind, want.data_byte,
                                 want.byte_offset, want.page_number, out_tuser,
                                 out_tdata[7:0], out_tdata[15:8], out_tdata[31:16]));
        end
      end
      results_checked++;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic build_frame(input logic [7:0] addr, input logic [15:0] page,
                             input logic [7:0] count_byte, input frame_fault_t fault);
    logic [15:0] crc;
    logic [7:0]  flip;
    int          pos;
    frame_bytes.delete();
    frame_bytes.push_back(addr);
    frame_bytes.push_back(mpfr_pkg::FUNC_CODE);
    frame_bytes.push_back(page[15:8]);
    frame_bytes.push_back(page[7:0]);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(count_byte);
    for (int i = 0; i < PAYLOAD; i++) frame_bytes.push_back(8'($urandom));
    crc = mpfr_pkg::CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_step(crc, frame_bytes[i]);
    flip = 8'($urandom_range(1, 255));
    case (fault)
      FAULT_DATA: begin
        pos = $urandom_range(7, 6 + PAYLOAD);
        frame_bytes[pos] = frame_bytes[pos] ^ flip;
      end
      FAULT_CRC_LO: crc[7:0] = crc[7:0] ^ flip;
      FAULT_CRC_HI: crc[15:8] = crc[15:8] ^ flip;
      default: ;
    endcase
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    frames_built++;
  endtask

  task automatic send_frame(input int from, input int upto);
    for (int i = from; i < upto; i++) queue_byte(frame_bytes[i]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0);
    // a trailing header byte may still be in flight with no result
    repeat (4) @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dev_addr = a;
    addr_settings++;
    @(negedge clk);
  endtask

  // one random chunk of traffic, mostly whole frames
  task automatic queue_episode();
    int           pick;
    int           n;
    logic [7:0]   b;
    logic [15:0]  page;
    logic [7:0]   count_byte;
    frame_fault_t fault;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        b = 8'($urandom);
        if (b == dev_addr) b = b ^ 8'h01;
        queue_byte(b);
      end
    end else if (pick < 16) begin
      b = 8'($urandom);
      if (b == mpfr_pkg::FUNC_CODE) b = b ^ 8'h01;
      queue_byte(dev_addr);
      queue_byte(b);
    end else if (pick < 19) begin
      // header cut short; following bytes get absorbed into this frame
      queue_byte(dev_addr);
      queue_byte(mpfr_pkg::FUNC_CODE);
      n = $urandom_range(1, 4);
      repeat (n) queue_byte(8'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0: page = 16'h0000;
        1: page = 16'hFFFF;
        default: page = 16'($urandom);
      endcase
      count_byte = ($urandom_range(0, 99) < 45) ? 8'h00 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 9))
        0: fault = FAULT_CRC_LO;
        1: fault = FAULT_CRC_HI;
        2, 3: fault = FAULT_DATA;
        default: fault = FAULT_NONE;
      endcase
      build_frame(dev_addr, page, count_byte, fault);
      send_frame(0, frame_bytes.size());
    end
  endtask

  initial begin
    logic [7:0] addr_plan[4];
    int         phase_idx;
    addr_plan = '{8'h00, 8'hFF, mpfr_pkg::FUNC_CODE, mpfr_pkg::ADDR_DEFAULT};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle bytes that are not the address
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(mpfr_pkg::ADDR_DEFAULT - 8'd1);
    queue_byte(mpfr_pkg::FUNC_CODE);
    // address twice: second one is a bad function, not a new start
    queue_byte(mpfr_pkg::ADDR_DEFAULT);
    queue_byte(mpfr_pkg::ADDR_DEFAULT);
    queue_byte(mpfr_pkg::FUNC_CODE);
    queue_byte(mpfr_pkg::ADDR_DEFAULT);
    queue_byte(8'h00);
    // good frame, more pages, address changed between the header and the payload
    build_frame(mpfr_pkg::ADDR_DEFAULT, 16'hFFFF, 8'h00, FAULT_NONE);
    send_frame(0, 7);
    wait_drained();
    write_address(8'hFF);
    send_frame(7, frame_bytes.size());
    // old address no longer matches
    queue_byte(mpfr_pkg::ADDR_DEFAULT);
    queue_byte(mpfr_pkg::FUNC_CODE);
    build_frame(8'hFF, 16'h0000, 8'hFF, FAULT_CRC_HI);
    send_frame(0, frame_bytes.size());
    build_frame(8'hFF, 16'h5AA5, 8'h01, FAULT_NONE);
    send_frame(0, frame_bytes.size());
    // long output stall while a full frame is still being offered
    long_stall_req = ~long_stall_req;

    phase_idx = 0;
    while (bytes_queued < 1300) begin
      wait_drained();
      if (phase_idx < 4) begin
        write_address(addr_plan[phase_idx]);
      end else begin
        write_address(8'($urandom));
      end
      queue_episode();
      if (phase_idx % 3 == 1) long_stall_req = ~long_stall_req;
      phase_idx++;
    end
    wait_drained();
    repeat (10) @(negedge clk);

    $display("run: %0d bytes in, %0d results (%0d data, %0d more-pages, %0d last, %0d crc err)",
             bytes_accepted, results_checked, outcome_count[mpfr_pkg::KIND_DATA],
             outcome_count[mpfr_pkg::KIND_MORE], outcome_count[mpfr_pkg::KIND_LAST],
             outcome_count[mpfr_pkg::KIND_CRC_ERR]);
    $display("run: %0d frames over %0d address writes, incl. mid-frame change and long stalls",
             frames_built, addr_settings);
    if (mismatch_count == 0) begin
      $display("modbus_page_frame_receiver_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("modbus_page_frame_receiver_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("modbus_page_frame_receiver_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mpfr_pkg.sv
rtl/core/mpfr_parser.sv
rtl/core/mpfr_out_reg.sv
rtl/core/modbus_page_frame_receiver.sv
tb/sv/modbus_page_frame_receiver_tb.sv
